@@ rtl/htw_pkg.sv @@
// Shared constants, types and state codes for the hierarchical timer wheel.
// No dependencies; htw_place and hierarchical_timer_wheel refer to it by scoped names.
package htw_pkg;

    localparam int SLOTS       = 64;  // slots per level, a power of two
    localparam int LEVELS      = 4;
    localparam int TIMER_COUNT = 64;
    localparam int TICK_BITS   = 32;

    localparam int ID_W      = 6;
    localparam int TICK_W    = 32;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int NSLOTS    = SLOTS * LEVELS;
    localparam int NS_W      = $clog2(NSLOTS);
    localparam int LV_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int IDX_W     = $clog2(TIMER_COUNT);

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_TOO_FAR = 2'd1,
        ST_PENDING = 2'd2,
        ST_EXPIRED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLACE_START,
        S_PLACE_WAIT,
        S_APP_WR,
        S_RESP,
        S_CASC_CHK,
        S_LIST_RD,
        S_ENT_RD,
        S_ENT_USE,
        S_EMIT,
        S_WALK_NEXT
    } t_state;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic            ok;
        logic [NS_W-1:0] slot;
    } t_place_res;

endpackage

@@ rtl/htw_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/htw_place.sv @@
// Level search: subtracts once, then shifts one level per cycle until it fits or reaches the last level.
// Depends on htw_pkg.
module htw_place (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [htw_pkg::TICK_BITS-1:0]  i_exp,
    input  logic [htw_pkg::TICK_BITS-1:0]  i_tick,
    output htw_pkg::t_place_res            o_res
);
    logic                          r_busy;
    logic [htw_pkg::TICK_BITS-1:0] r_left;
    logic [htw_pkg::TICK_BITS-1:0] r_exp;
    logic [htw_pkg::LV_W-1:0]      r_lv;
    logic                          fit;
    logic                          last;

    assign fit  = r_left < htw_pkg::TICK_BITS'(htw_pkg::SLOTS);
    assign last = r_lv == htw_pkg::LV_W'(htw_pkg::LEVELS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_left <= i_exp - i_tick;
            r_exp  <= i_exp;
            r_lv   <= '0;
        end else if (r_busy) begin
            if (fit || last) begin
                r_busy <= 1'b0;
            end else begin
                r_left <= r_left >> htw_pkg::SLOT_BITS;
                r_exp  <= r_exp >> htw_pkg::SLOT_BITS;
                r_lv   <= r_lv + htw_pkg::LV_W'(1);
            end
        end
    end

    always_comb begin
        o_res.busy = r_busy;
        o_res.done = r_busy && (fit || last);
        o_res.ok   = fit;
        o_res.slot = htw_pkg::NS_W'({r_lv, r_exp[htw_pkg::SLOT_BITS-1:0]});
    end
endmodule

@@ rtl/hierarchical_timer_wheel.sv @@
// Hierarchical timer wheel: LEVELS wheels of SLOTS slots over a pool of timers.
// Add: a rejected id goes straight to the response, else the level search shifts one
// level per cycle and an occupied slot takes a tail append; one result, registered.
// Tick: checks each cascading higher level, opens each occupied list, re-places each
// cascaded timer and emits each expired timer, held by output stalls. Input is stalled
// until a transaction is fully handled. Sync active-low reset clears counter and bits.
module hierarchical_timer_wheel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [5:0]  i_timer_id,
    input  logic [31:0] i_delay_ticks,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_id,
    output logic        o_last_of_run,
    output logic [31:0] o_tick_now
);
    localparam int TB  = htw_pkg::TICK_BITS;
    localparam int SB  = htw_pkg::SLOT_BITS;
    localparam int NSW = htw_pkg::NS_W;
    localparam int IW  = htw_pkg::IDX_W;
    localparam int LW  = htw_pkg::LV_W;

    htw_pkg::t_state r_state, n_state;

    // sequencer registers
    logic [TB-1:0]  r_tick, r_digits, r_exp;
    logic [LW-1:0]  r_lv;
    logic           r_emit_mode;        // 1 = emitting level 0, 0 = cascading
    logic [IW-1:0]  r_id, r_cur, r_fin, r_nxt, r_n;
    logic [NSW-1:0] r_slot;
    logic [1:0]     r_res_status;
    logic [5:0]     r_res_id;
    logic           r_occ  [htw_pkg::NSLOTS];
    logic           r_pend [htw_pkg::TIMER_COUNT];

    // output register
    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [5:0]     r_out_id;
    logic           r_out_last;
    logic [TB-1:0]  r_out_tnow;

    // control
    logic            in_acc, out_free, id_bad, casc_go, walk_more;
    logic            place_start;
    logic [TB-1:0]   tick_inc, exp_sum, casc_digits;
    logic [NSW-1:0]  casc_slot, emit_slot, chk_slot;
    htw_pkg::t_place_res place_res;

    // RAM ports
    logic            exp_we, link_we, first_we, final_we;
    logic [IW-1:0]   exp_addr, link_addr;
    logic [NSW-1:0]  first_addr, final_addr;
    logic [TB-1:0]   exp_rdata;
    logic [IW-1:0]   link_rdata, first_rdata, final_rdata;

    assign in_acc    = i_in_valid && (r_state == htw_pkg::S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign id_bad    = ({1'b0, i_timer_id} >= 7'(htw_pkg::TIMER_COUNT))
                       || r_pend[i_timer_id[IW-1:0]];
    assign tick_inc  = r_tick + TB'(1);
    assign exp_sum   = r_tick + TB'(i_delay_ticks);
    // next level cascades when the lower digits of the new counter are all zero
    assign casc_go     = (r_lv != LW'(htw_pkg::LEVELS - 1)) && (r_digits[SB-1:0] == '0);
    assign casc_digits = r_digits >> SB;
    assign casc_slot   = NSW'({r_lv + LW'(1), casc_digits[SB-1:0]});
    assign emit_slot   = NSW'(r_tick[SB-1:0]);
    assign chk_slot    = casc_go ? casc_slot : emit_slot;
    assign walk_more   = (r_cur != r_fin) && (r_n != IW'(htw_pkg::TIMER_COUNT - 1));
    assign place_start = (r_state == htw_pkg::S_PLACE_START);

    htw_place u_place (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (place_start),
        .i_exp   (r_exp),
        .i_tick  (r_tick),
        .o_res   (place_res)
    );

    htw_ram #(.WIDTH(TB), .DEPTH(htw_pkg::TIMER_COUNT)) u_expiry (
        .i_clk(i_clk), .i_we(exp_we), .i_addr(exp_addr),
        .i_wdata(exp_sum), .o_rdata(exp_rdata)
    );
    htw_ram #(.WIDTH(IW), .DEPTH(htw_pkg::TIMER_COUNT)) u_link (
        .i_clk(i_clk), .i_we(link_we), .i_addr(link_addr),
        .i_wdata(r_id), .o_rdata(link_rdata)
    );
    htw_ram #(.WIDTH(IW), .DEPTH(htw_pkg::NSLOTS)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_addr(first_addr),
        .i_wdata(r_id), .o_rdata(first_rdata)
    );
    htw_ram #(.WIDTH(IW), .DEPTH(htw_pkg::NSLOTS)) u_final (
        .i_clk(i_clk), .i_we(final_we), .i_addr(final_addr),
        .i_wdata(r_id), .o_rdata(final_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            htw_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_req_type) n_state = htw_pkg::S_CASC_CHK;
                    else if (id_bad) n_state = htw_pkg::S_RESP;
                    else n_state = htw_pkg::S_PLACE_START;
                end
            end
            htw_pkg::S_PLACE_START: n_state = htw_pkg::S_PLACE_WAIT;
            htw_pkg::S_PLACE_WAIT: begin
                if (place_res.done) begin
                    if (place_res.ok && r_occ[place_res.slot]) n_state = htw_pkg::S_APP_WR;
                    else if (r_emit_mode) n_state = htw_pkg::S_RESP;  // add path
                    else n_state = htw_pkg::S_WALK_NEXT;
                end
            end
            htw_pkg::S_APP_WR: begin
                n_state = r_emit_mode ? htw_pkg::S_RESP : htw_pkg::S_WALK_NEXT;
            end
            htw_pkg::S_RESP: begin
                if (out_free) n_state = htw_pkg::S_IDLE;
            end
            htw_pkg::S_CASC_CHK: begin
                if (r_occ[chk_slot]) begin
                    n_state = htw_pkg::S_LIST_RD;
                end else if (!casc_go) begin
                    n_state = htw_pkg::S_IDLE;
                end
            end
            htw_pkg::S_LIST_RD: n_state = htw_pkg::S_ENT_RD;
            htw_pkg::S_ENT_RD:  n_state = htw_pkg::S_ENT_USE;
            htw_pkg::S_ENT_USE: begin
                n_state = r_emit_mode ? htw_pkg::S_EMIT : htw_pkg::S_PLACE_START;
            end
            htw_pkg::S_EMIT: begin
                if (out_free) n_state = htw_pkg::S_WALK_NEXT;
            end
            htw_pkg::S_WALK_NEXT: begin
                if (walk_more) n_state = htw_pkg::S_ENT_RD;
                else if (r_emit_mode) n_state = htw_pkg::S_IDLE;
                else n_state = htw_pkg::S_CASC_CHK;
            end
            default: n_state = htw_pkg::S_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        exp_we     = in_acc && !i_req_type && !id_bad;
        exp_addr   = in_acc ? i_timer_id[IW-1:0] : r_cur;
        link_we    = 1'b0;
        link_addr  = r_cur;
        first_we   = 1'b0;
        first_addr = place_res.slot;
        final_we   = 1'b0;
        final_addr = place_res.slot;
        case (r_state)
            htw_pkg::S_PLACE_WAIT: begin
                // empty slot: start a new list; occupied slot: fetch its tail
                if (place_res.done && place_res.ok && !r_occ[place_res.slot]) begin
                    first_we = 1'b1;
                    final_we = 1'b1;
                end
            end
            htw_pkg::S_APP_WR: begin
                link_we    = 1'b1;
                link_addr  = final_rdata;
                final_we   = 1'b1;
                final_addr = r_slot;
            end
            htw_pkg::S_CASC_CHK: begin
                first_addr = chk_slot;
                final_addr = chk_slot;
            end
            default: begin
            end
        endcase
    end

    // control state: sequencer, tick counter, occupancy and pending bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htw_pkg::S_IDLE;
            r_tick  <= '0;
            for (int i = 0; i < htw_pkg::NSLOTS; i++) r_occ[i] <= 1'b0;
            for (int i = 0; i < htw_pkg::TIMER_COUNT; i++) r_pend[i] <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                htw_pkg::S_IDLE: begin
                    if (in_acc && i_req_type) r_tick <= tick_inc;
                end
                htw_pkg::S_PLACE_WAIT: begin
                    if (place_res.done) begin
                        if (place_res.ok) begin
                            r_occ[place_res.slot] <= 1'b1;
                            if (r_emit_mode) r_pend[r_id] <= 1'b1;
                        end else if (!r_emit_mode) begin
                            r_pend[r_id] <= 1'b0;  // cascaded timer fits nowhere
                        end
                    end
                end
                htw_pkg::S_CASC_CHK: begin
                    r_occ[chk_slot] <= 1'b0;
                end
                htw_pkg::S_EMIT: begin
                    if (out_free) r_pend[r_cur] <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            htw_pkg::S_IDLE: begin
                r_res_id    <= i_timer_id;
                r_id        <= i_timer_id[IW-1:0];
                r_exp       <= exp_sum;
                r_digits    <= tick_inc;
                r_lv        <= '0;
                // add path reuses the mode flag to route back to the response
                r_emit_mode <= !i_req_type;
                r_res_status <= id_bad ? htw_pkg::ST_PENDING : htw_pkg::ST_ADDED;
            end
            htw_pkg::S_PLACE_WAIT: begin
                r_slot <= place_res.slot;
                if (place_res.done && !place_res.ok) r_res_status <= htw_pkg::ST_TOO_FAR;
            end
            htw_pkg::S_CASC_CHK: begin
                if (casc_go) begin
                    r_digits <= casc_digits;
                    r_lv     <= r_lv + LW'(1);
                    r_emit_mode <= 1'b0;
                end else begin
                    r_emit_mode <= 1'b1;
                end
            end
            htw_pkg::S_LIST_RD: begin
                r_cur <= first_rdata;
                r_fin <= final_rdata;
                r_n   <= '0;
            end
            htw_pkg::S_ENT_USE: begin
                r_nxt <= link_rdata;
                r_exp <= exp_rdata;
                r_id  <= r_cur;
            end
            htw_pkg::S_WALK_NEXT: begin
                r_cur <= r_nxt;
                r_n   <= r_n + IW'(1);
            end
            default: begin
            end
        endcase
    end

    // output register; the add path sets the mode flag, so r_emit_mode stays
    // meaningful only inside a tick walk, checked by state here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == htw_pkg::S_RESP && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_state == htw_pkg::S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == htw_pkg::S_RESP && out_free) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_last   <= 1'b1;
            r_out_tnow   <= r_tick;
        end else if (r_state == htw_pkg::S_EMIT && out_free) begin
            r_out_status <= htw_pkg::ST_EXPIRED;
            r_out_id     <= 6'(r_cur);
            r_out_last   <= !walk_more;
            r_out_tnow   <= r_tick;
        end
    end

    // held in stall during reset so no transaction is taken then
    assign o_in_stall    = !i_rst_n || (r_state != htw_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_result_id   = r_out_id;
    assign o_last_of_run = r_out_last;
    assign o_tick_now    = 32'(r_out_tnow);

    // the level search is never restarted while it runs
    a_place_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        place_start |-> !place_res.busy)
        else $error("level search restarted while busy");

    // an append only follows a lookup of an occupied slot
    a_append_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htw_pkg::S_APP_WR) |-> r_occ[r_slot])
        else $error("tail append into an empty slot");

    // the counter moves only on an accepted tick
    a_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_acc && i_req_type) |=> $stable(r_tick))
        else $error("tick counter moved without a tick");

    // a held result is not overwritten by the sequencer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_id)))
        else $error("stalled result overwritten");
endmodule
